/* src/nsp_pkg.sv */
// Package for the numeric string parser: types, constants and helper functions.
// Used by every module of the parser; it has no dependencies of its own.
package nsp_pkg;

    localparam int OFFSET_BITS_DEFAULT = 16;
    localparam int VALUE_W             = 63;
    localparam int RADIX_W             = 6;
    localparam int DIGIT_W             = 7;
    localparam int PADDR_W             = 3;
    localparam int PDATA_W             = 32;

    localparam logic [VALUE_W-1:0] MAX_VALUE = {VALUE_W{1'b1}};

    localparam logic [RADIX_W-1:0] RADIX_AUTO  = 6'd0;
    localparam logic [RADIX_W-1:0] RADIX_ONE   = 6'd1;
    localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
    localparam logic [RADIX_W-1:0] RADIX_OCT   = 6'd8;
    localparam logic [RADIX_W-1:0] RADIX_DEC   = 6'd10;
    localparam logic [RADIX_W-1:0] RADIX_HEX   = 6'd16;
    localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;
    localparam logic [RADIX_W-1:0] BASE_RESET  = 6'd10;

    localparam logic [DIGIT_W-1:0] DIGIT_NONE  = 7'd99;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UX    = 8'h58;
    localparam logic [7:0] CH_UZ    = 8'h5A;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LX    = 8'h78;
    localparam logic [7:0] CH_LZ    = 8'h7A;

    // Register index of the only configuration register.
    localparam logic [PADDR_W-3:0] REG_BASE_SETTING = 1'b0;

    typedef enum logic [2:0] {
        PH_SPACE  = 3'd0,
        PH_SIGN   = 3'd1,
        PH_ZERO   = 3'd2,
        PH_DIGITS = 3'd3,
        PH_HEXPFX = 3'd4,
        PH_STOP   = 3'd5
    } phase_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NO_NUMBER = 2'd1,
        ST_BAD_BASE  = 2'd2,
        ST_OVERFLOW  = 2'd3
    } status_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } item_t;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        status_t            status;
    } result_t;

    function automatic logic radix_invalid(input logic [RADIX_W-1:0] r);
        return (r == RADIX_ONE) || (r > RADIX_MAX);
    endfunction

    function automatic logic [DIGIT_W-1:0] digit_value(input logic [7:0] c);
        logic [DIGIT_W-1:0] d;
        d = DIGIT_NONE;
        if (c >= CH_ZERO && c <= CH_NINE)
        begin
            d = DIGIT_W'(c - CH_ZERO);
        end
        else if (c >= CH_LA && c <= CH_LZ)
        begin
            d = DIGIT_W'(c - CH_LA) + 7'd10;
        end
        else if (c >= CH_UA && c <= CH_UZ)
        begin
            d = DIGIT_W'(c - CH_UA) + 7'd10;
        end
        return d;
    endfunction

endpackage

/* src/nsp_in_stage.sv */
// Input register of the numeric string parser: holds one character item.
// Depends on nsp_pkg for the item type.
module nsp_in_stage (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  logic [7:0]    ch,
    input  logic          last,
    output logic          in_stall,
    input  logic          take,
    output logic          s1_valid,
    output nsp_pkg::item_t s1_item
);

    logic           valid_reg;
    logic           valid_next;
    nsp_pkg::item_t item_reg;
    logic           load;

    assign in_stall   = valid_reg && !take;
    assign load       = in_valid && !in_stall;
    assign valid_next = load ? 1'b1 : (take ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg.ch   <= ch;
            item_reg.last <= last;
        end
    end

    assign s1_valid = valid_reg;
    assign s1_item  = item_reg;

endmodule

/* src/nsp_core.sv */
// Parse state and the per-character update of the numeric string parser.
// Depends on nsp_pkg for phases, status codes, character codes and helpers.
module nsp_core #(
    parameter int OFFSET_BITS = nsp_pkg::OFFSET_BITS_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [nsp_pkg::RADIX_W-1:0]   base,
    input  logic                          s1_valid,
    input  nsp_pkg::item_t                s1_item,
    input  logic                          out_free,
    output logic                          take,
    output logic                          emit_load,
    output nsp_pkg::result_t              res,
    output logic [OFFSET_BITS-1:0]        res_end_offset
);

    localparam int VW  = nsp_pkg::VALUE_W;
    localparam int RW  = nsp_pkg::RADIX_W;
    localparam int PW  = VW + RW + 1;

    nsp_pkg::phase_t      phase_reg, phase_next;
    logic [VW-1:0]        acc_reg, acc_next;
    logic [RW-1:0]        radix_reg, radix_next;
    logic                 ovf_reg, ovf_next;
    logic [OFFSET_BITS-1:0] pos_reg, pos_next;
    logic [OFFSET_BITS-1:0] endp_reg, endp_next;
    logic                 dseen_reg, dseen_next;

    nsp_pkg::phase_t      ph_upd;
    logic [VW-1:0]        acc_upd;
    logic [RW-1:0]        radix_upd;
    logic                 ovf_upd;
    logic [OFFSET_BITS-1:0] endp_upd;
    logic                 dseen_upd;

    logic                 first;
    logic [RW-1:0]        r0;
    nsp_pkg::phase_t      p0;
    logic [OFFSET_BITS-1:0] pos_inc;
    logic                 is_nul;
    logic                 emit;
    logic                 do_digit;
    logic [RW-1:0]        dr;
    logic [nsp_pkg::DIGIT_W-1:0] dval;
    logic [PW-1:0]        prod;
    logic                 digit_ok;

    assign is_nul    = (s1_item.ch == nsp_pkg::CH_NUL);
    assign emit      = is_nul || s1_item.last;
    assign take      = s1_valid && (!emit || out_free);
    assign emit_load = take && emit;

    assign first   = (pos_reg == '0) && (phase_reg == nsp_pkg::PH_SPACE) && !dseen_reg;
    assign r0      = first ? base : radix_reg;
    assign p0      = (first && nsp_pkg::radix_invalid(base)) ? nsp_pkg::PH_STOP : phase_reg;
    assign pos_inc = (pos_reg == '1) ? pos_reg : pos_reg + 1'b1;
    assign dval    = nsp_pkg::digit_value(s1_item.ch);

    // Radix selection: decide whether this character goes to the digit step.
    always_comb
    begin
        do_digit = 1'b0;
        dr       = r0;
        if (!is_nul)
        begin
            case (p0)
                nsp_pkg::PH_SPACE, nsp_pkg::PH_SIGN:
                begin
                    if (!(p0 == nsp_pkg::PH_SPACE &&
                          (s1_item.ch == nsp_pkg::CH_SPACE || s1_item.ch == nsp_pkg::CH_TAB ||
                           s1_item.ch == nsp_pkg::CH_LF || s1_item.ch == nsp_pkg::CH_CR ||
                           s1_item.ch == nsp_pkg::CH_PLUS)) &&
                        !(s1_item.ch == nsp_pkg::CH_ZERO &&
                          (r0 == nsp_pkg::RADIX_AUTO || r0 == nsp_pkg::RADIX_HEX)))
                    begin
                        do_digit = 1'b1;
                        dr       = (r0 == nsp_pkg::RADIX_AUTO) ? nsp_pkg::RADIX_DEC : r0;
                    end
                end
                nsp_pkg::PH_ZERO:
                begin
                    if (!(s1_item.ch == nsp_pkg::CH_LX || s1_item.ch == nsp_pkg::CH_UX))
                    begin
                        do_digit = 1'b1;
                        dr       = (r0 == nsp_pkg::RADIX_AUTO) ? nsp_pkg::RADIX_OCT : r0;
                    end
                end
                nsp_pkg::PH_DIGITS, nsp_pkg::PH_HEXPFX:
                begin
                    do_digit = 1'b1;
                end
                default:
                begin
                    do_digit = 1'b0;
                end
            endcase
        end
    end

    assign prod     = PW'(acc_reg) * PW'(dr) + PW'(dval);
    assign digit_ok = (dr >= nsp_pkg::RADIX_MIN) && (dr <= nsp_pkg::RADIX_MAX) &&
                      (dval < nsp_pkg::DIGIT_W'(dr));

    // Next-state logic for the parse phase and the datapath.
    always_comb
    begin
        ph_upd    = p0;
        acc_upd   = acc_reg;
        radix_upd = r0;
        ovf_upd   = ovf_reg;
        endp_upd  = endp_reg;
        dseen_upd = dseen_reg;
        if (do_digit)
        begin
            radix_upd = dr;
            if (!digit_ok)
            begin
                ph_upd = nsp_pkg::PH_STOP;
            end
            else
            begin
                if (prod[PW-1:VW] != '0)
                begin
                    ovf_upd = 1'b1;
                end
                else
                begin
                    acc_upd = prod[VW-1:0];
                end
                dseen_upd = 1'b1;
                endp_upd  = pos_inc;
                ph_upd    = nsp_pkg::PH_DIGITS;
            end
        end
        else if (!is_nul)
        begin
            case (p0)
                nsp_pkg::PH_SPACE, nsp_pkg::PH_SIGN:
                begin
                    if (p0 == nsp_pkg::PH_SPACE && s1_item.ch == nsp_pkg::CH_PLUS)
                    begin
                        ph_upd = nsp_pkg::PH_SIGN;
                    end
                    else if (s1_item.ch == nsp_pkg::CH_ZERO)
                    begin
                        dseen_upd = 1'b1;
                        endp_upd  = pos_inc;
                        ph_upd    = nsp_pkg::PH_ZERO;
                    end
                end
                nsp_pkg::PH_ZERO:
                begin
                    radix_upd = nsp_pkg::RADIX_HEX;
                    dseen_upd = 1'b0;
                    endp_upd  = '0;
                    ph_upd    = nsp_pkg::PH_HEXPFX;
                end
                default:
                begin
                    ph_upd = p0;
                end
            endcase
        end

        if (emit)
        begin
            phase_next = nsp_pkg::PH_SPACE;
            acc_next   = '0;
            radix_next = '0;
            ovf_next   = 1'b0;
            pos_next   = '0;
            endp_next  = '0;
            dseen_next = 1'b0;
        end
        else
        begin
            phase_next = ph_upd;
            acc_next   = acc_upd;
            radix_next = radix_upd;
            ovf_next   = ovf_upd;
            pos_next   = pos_inc;
            endp_next  = endp_upd;
            dseen_next = dseen_upd;
        end
    end

    // Result of the string as it stands after this character.
    always_comb
    begin
        res.value      = '0;
        res_end_offset = '0;
        if (nsp_pkg::radix_invalid(radix_upd))
        begin
            res.status = nsp_pkg::ST_BAD_BASE;
        end
        else if (!dseen_upd)
        begin
            res.status = nsp_pkg::ST_NO_NUMBER;
        end
        else if (ovf_upd)
        begin
            res.status = nsp_pkg::ST_OVERFLOW;
        end
        else
        begin
            res.status     = nsp_pkg::ST_OK;
            res.value      = acc_upd;
            res_end_offset = endp_upd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= nsp_pkg::PH_SPACE;
            acc_reg   <= '0;
            radix_reg <= '0;
            ovf_reg   <= 1'b0;
            pos_reg   <= '0;
            endp_reg  <= '0;
            dseen_reg <= 1'b0;
        end
        else if (take)
        begin
            phase_reg <= phase_next;
            acc_reg   <= acc_next;
            radix_reg <= radix_next;
            ovf_reg   <= ovf_next;
            pos_reg   <= pos_next;
            endp_reg  <= endp_next;
            dseen_reg <= dseen_next;
        end
    end

endmodule

/* src/nsp_out_stage.sv */
// Result register of the numeric string parser: holds one result item.
// Depends on nsp_pkg for the result type.
module nsp_out_stage #(
    parameter int OFFSET_BITS = nsp_pkg::OFFSET_BITS_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          emit_load,
    input  nsp_pkg::result_t              res,
    input  logic [OFFSET_BITS-1:0]        res_end_offset,
    output logic                          out_free,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [nsp_pkg::VALUE_W-1:0]   value,
    output logic [OFFSET_BITS-1:0]        end_offset,
    output logic [1:0]                    status
);

    logic                   valid_reg;
    logic                   valid_next;
    nsp_pkg::result_t       res_reg;
    logic [OFFSET_BITS-1:0] end_offset_reg;

    assign out_free   = !valid_reg || !out_stall;
    assign valid_next = emit_load ? 1'b1 : (out_free ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit_load)
        begin
            res_reg        <= res;
            end_offset_reg <= res_end_offset;
        end
    end

    assign out_valid  = valid_reg;
    assign value      = res_reg.value;
    assign end_offset = end_offset_reg;
    assign status     = res_reg.status;

endmodule

/* src/numeric_string_to_u63_parser_unit.sv */
// Top level of the numeric string parser: base register, input stage, core, result stage.
// Depends on nsp_pkg, nsp_in_stage, nsp_core and nsp_out_stage.
//
//   channel   handshake            payload
//   input     in_valid / in_stall  ch[7:0], last
//   result    out_valid/out_stall  value[62:0], end_offset[OFFSET_BITS-1:0], status[1:0]
//   config    APB psel/penable     paddr[2:0], pwdata[31:0], prdata[31:0]
//
// One character is taken per cycle unless stalled; the radix multiply-add sets the cycle.
// The result stage registers a result item when the core takes the character ending the string.
// Reset clears the parse state, sets base_setting to 10 and empties both registers.
// A stalled result stops the input only when the next item would also produce a result.
module numeric_string_to_u63_parser_unit #(
    parameter int OFFSET_BITS = nsp_pkg::OFFSET_BITS_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [7:0]                    ch,
    input  logic                          last,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [nsp_pkg::VALUE_W-1:0]   value,
    output logic [OFFSET_BITS-1:0]        end_offset,
    output logic [1:0]                    status,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [nsp_pkg::PADDR_W-1:0]   paddr,
    input  logic [nsp_pkg::PDATA_W-1:0]   pwdata,
    output logic [nsp_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready
);

    logic [nsp_pkg::RADIX_W-1:0] base_reg;
    logic                        cfg_wr;
    logic                        take;
    logic                        s1_valid;
    nsp_pkg::item_t              s1_item;
    logic                        out_free;
    logic                        emit_load;
    nsp_pkg::result_t            res;
    logic [OFFSET_BITS-1:0]      res_end_offset;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready &&
                    (paddr[nsp_pkg::PADDR_W-1:2] == nsp_pkg::REG_BASE_SETTING);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg <= nsp_pkg::BASE_RESET;
        end
        else if (cfg_wr)
        begin
            base_reg <= pwdata[nsp_pkg::RADIX_W-1:0];
        end
    end

    assign prdata = (paddr[nsp_pkg::PADDR_W-1:2] == nsp_pkg::REG_BASE_SETTING) ?
                    nsp_pkg::PDATA_W'(base_reg) : '0;

    nsp_in_stage u_in (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .ch       (ch),
        .last     (last),
        .in_stall (in_stall),
        .take     (take),
        .s1_valid (s1_valid),
        .s1_item  (s1_item)
    );

    nsp_core #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_core (
        .clk            (clk),
        .rst_n          (rst_n),
        .base           (base_reg),
        .s1_valid       (s1_valid),
        .s1_item        (s1_item),
        .out_free       (out_free),
        .take           (take),
        .emit_load      (emit_load),
        .res            (res),
        .res_end_offset (res_end_offset)
    );

    nsp_out_stage #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_out (
        .clk            (clk),
        .rst_n          (rst_n),
        .emit_load      (emit_load),
        .res            (res),
        .res_end_offset (res_end_offset),
        .out_free       (out_free),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .value          (value),
        .end_offset     (end_offset),
        .status         (status)
    );

endmodule

/* src/nsp_checker.sv */
// Port-level checks for the numeric string parser, bound to the top level.
// Depends on nsp_pkg and numeric_string_to_u63_parser_unit.
module nsp_checker #(
    parameter int OFFSET_BITS = nsp_pkg::OFFSET_BITS_DEFAULT
) (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_stall,
    input logic                          out_valid,
    input logic                          out_stall,
    input logic [nsp_pkg::VALUE_W-1:0]   value,
    input logic [OFFSET_BITS-1:0]        end_offset,
    input logic [1:0]                    status
);

    // The input is held back only by a result item that is waiting.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("input stalled without a waiting result item");

    // Any status other than ok carries a zero value and a zero offset.
    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status != nsp_pkg::ST_OK) |-> (value == '0 && end_offset == '0))
        else $error("error result item carries a value or offset");

    // An ok result has consumed at least one digit.
    a_ok_offset: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == nsp_pkg::ST_OK) |-> (end_offset != '0))
        else $error("ok result item with zero end offset");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> out_valid)
        else $error("result item dropped while stalled");

endmodule

bind numeric_string_to_u63_parser_unit nsp_checker #(
    .OFFSET_BITS (OFFSET_BITS)
) u_nsp_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .value      (value),
    .end_offset (end_offset),
    .status     (status)
);
